FILE: src/gdc_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date calculator.
package gdc_pkg;

  // Datapath widths
  localparam int SER_W  = 23;   // day serial number
  localparam int N_W    = 22;   // zero-based serial of an in-range date
  localparam int SY_W   = 15;   // shifted year
  localparam int MA_W   = 22;   // multiplier operand A
  localparam int MB_W   = 16;   // multiplier operand B
  localparam int PROD_W = MA_W + MB_W;
  localparam int Q100_LSB = 19; // sy * RECIP_100 >> Q100_LSB == sy / 100
  localparam int YEAR_LSB = 24; // n * RECIP_YEAR >> YEAR_LSB ~= n / 365.2425

  localparam logic [SY_W-1:0]  YEAR_SHIFT = 15'd400;
  localparam logic [MB_W-1:0]  RECIP_100  = 16'd5243;
  localparam logic [MB_W-1:0]  RECIP_YEAR = 16'd45934;
  localparam logic [MB_W-1:0]  YEAR_DAYS  = 16'd365;

  // Serials of 1 Jan 1 and 31 Dec 9999
  localparam logic [SER_W-1:0] SERIAL_LO  = 23'd146098;
  localparam logic [SER_W-1:0] SERIAL_HI  = 23'd3798156;
  localparam logic [SER_W-1:0] DIFF_MAX   = 23'd4194303;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_DIFF = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_YDIV   = 10'b00_0000_0010,
    ST_YMUL   = 10'b00_0000_0100,
    ST_YSUM   = 10'b00_0000_1000,
    ST_SER    = 10'b00_0001_0000,
    ST_DECIDE = 10'b00_0010_0000,
    ST_EST    = 10'b00_0100_0000,
    ST_ESTL   = 10'b00_1000_0000,
    ST_YCHK   = 10'b01_0000_0000,
    ST_MON    = 10'b10_0000_0000
  } state_t;

  // Days before the first of month index mi (0 = January), non-leap year
  function automatic logic [8:0] cum_days(input logic [3:0] mi);
    logic [8:0] res;
    case (mi)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] res;
    case (mo)
      4'd1:                 res = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: res = 5'd30;
      default:              res = 5'd31;
    endcase
    return res;
  endfunction

endpackage

FILE: src/gregorian_date_calculator.sv
// Gregorian date calculator: add/subtract days, day difference, date compare.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | in_cmd, in_day/month/year_a/_b,         | start && !busy
//           | in_day_count                            |
//  result   | out_day, out_month, out_year,           | out_valid, one cycle,
//           | out_diff_days, out_a_*, out_range_error | no backpressure
//
//  Each date is turned into a day serial by one shared multiplier (year part in ST_YDIV,
//  ST_YMUL and ST_YSUM, month/day add in ST_SER); ST_DECIDE then answers compare/difference.
//  Add/subtract then converts back: year estimate (ST_EST, ST_ESTL), one or two year passes
//  (ST_YDIV, ST_YMUL, ST_YSUM, ST_YCHK), and a month walk over at most 12 months in ST_MON.
//  busy is high from acceptance until the cycle before out_valid.
//  Synchronous active-low reset returns the sequencer to idle with no result pending.
module gregorian_date_calculator #(
  parameter int DAY_COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_cmd,
  input  logic [4:0]                in_day_a,
  input  logic [3:0]                in_month_a,
  input  logic [13:0]               in_year_a,
  input  logic [4:0]                in_day_b,
  input  logic [3:0]                in_month_b,
  input  logic [13:0]               in_year_b,
  input  logic [DAY_COUNT_BITS-1:0] in_day_count,
  output logic                      out_valid,
  output logic [4:0]                out_day,
  output logic [3:0]                out_month,
  output logic [13:0]               out_year,
  output logic signed [22:0]        out_diff_days,
  output logic                      out_a_before_b,
  output logic                      out_a_equals_b,
  output logic                      out_range_error
);

  localparam int SUM_W = ((DAY_COUNT_BITS > gdc_pkg::SER_W) ?
                          DAY_COUNT_BITS : gdc_pkg::SER_W) + 1;

  gdc_pkg::state_t state_r, state_nxt;
  gdc_pkg::cmd_t   cmd_r, cmd_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            sel_b_r, sel_b_nxt;
  // set while the year loop serves the serial-to-date conversion
  logic            conv_phase_r, conv_phase_nxt;

  logic [4:0]  day_a_r, day_a_nxt, day_b_r, day_b_nxt;
  logic [3:0]  month_a_r, month_a_nxt, month_b_r, month_b_nxt;
  logic [13:0] year_b_r, year_b_nxt;
  logic [DAY_COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [gdc_pkg::SY_W-1:0]   sy_r, sy_nxt;
  logic [gdc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [7:0]                 q100p_r, q100p_nxt;
  logic                       leap_r, leap_nxt;
  logic [gdc_pkg::SER_W-1:0]  d_r, d_nxt;
  logic [gdc_pkg::SER_W-1:0]  sa_r, sa_nxt, sb_r, sb_nxt;
  logic [gdc_pkg::N_W-1:0]    n_r, n_nxt;
  logic [8:0]                 doy_r, doy_nxt;
  logic [3:0]                 mo_r, mo_nxt;

  logic [4:0]  out_day_r, out_day_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [13:0] out_year_r, out_year_nxt;
  logic [22:0] out_diff_r, out_diff_nxt;
  logic        out_before_r, out_before_nxt;
  logic        out_equal_r, out_equal_nxt;
  logic        out_rerr_r, out_rerr_nxt;

  // Shared multiplier
  logic [gdc_pkg::MA_W-1:0] mul_a;
  logic [gdc_pkg::MB_W-1:0] mul_b;

  // Year-to-serial helpers
  logic [gdc_pkg::SY_W-1:0]  sy_m1;
  logic [7:0]                q_est;
  logic [gdc_pkg::SY_W-1:0]  q_times100;
  logic [gdc_pkg::SY_W-1:0]  r100;
  logic [gdc_pkg::SER_W-1:0] d_sum;

  // Month/day add
  logic [4:0]                day_sel;
  logic [3:0]                month_sel, month_cl;
  logic [gdc_pkg::SER_W-1:0] s_val;

  // Decision
  logic [SUM_W-1:0]          sa_ext, cnt_ext, rs;
  logic                      rs_ok;
  logic [gdc_pkg::SER_W-1:0] diff_raw;

  // Year check and month walk
  logic [gdc_pkg::SER_W-1:0] dd;
  logic [8:0]                ylen;
  logic [4:0]                mlen;

  assign prod_nxt = gdc_pkg::PROD_W'(mul_a) * gdc_pkg::PROD_W'(mul_b);

  always_comb begin
    case (state_r)
      gdc_pkg::ST_YDIV: begin
        mul_a = gdc_pkg::MA_W'(sy_r);
        mul_b = gdc_pkg::RECIP_100;
      end
      gdc_pkg::ST_YMUL: begin
        mul_a = gdc_pkg::MA_W'(sy_m1);
        mul_b = gdc_pkg::YEAR_DAYS;
      end
      gdc_pkg::ST_EST: begin
        mul_a = n_r;
        mul_b = gdc_pkg::RECIP_YEAR;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sy_m1      = sy_r - gdc_pkg::SY_W'(1);
  assign q_est      = prod_r[gdc_pkg::Q100_LSB+7:gdc_pkg::Q100_LSB];
  assign q_times100 = (gdc_pkg::SY_W'(q_est) << 6) + (gdc_pkg::SY_W'(q_est) << 5) +
                      (gdc_pkg::SY_W'(q_est) << 2);
  assign r100       = sy_r - q_times100;
  // days before the shifted year: 365p + p/4 - p/100 + p/400 with p = sy - 1
  assign d_sum = prod_r[gdc_pkg::SER_W-1:0] + gdc_pkg::SER_W'(sy_m1 >> 2)
               - gdc_pkg::SER_W'(q100p_r) + gdc_pkg::SER_W'(q100p_r >> 2);

  assign day_sel   = sel_b_r ? day_b_r : day_a_r;
  assign month_sel = sel_b_r ? month_b_r : month_a_r;
  assign month_cl  = (month_sel == 4'd0) ? 4'd1 : ((month_sel > 4'd12) ? 4'd12 : month_sel);
  assign s_val = d_r + gdc_pkg::SER_W'(gdc_pkg::cum_days(month_cl - 4'd1))
               + gdc_pkg::SER_W'(day_sel) + gdc_pkg::SER_W'(leap_r && (month_cl > 4'd2));

  assign sa_ext  = SUM_W'(sa_r);
  assign cnt_ext = SUM_W'(cnt_r);
  assign rs      = (cmd_r == gdc_pkg::CMD_ADD) ? (sa_ext + cnt_ext) : (sa_ext - cnt_ext);
  assign rs_ok   = ((cmd_r == gdc_pkg::CMD_ADD) || (sa_ext >= cnt_ext)) &&
                   (rs >= SUM_W'(gdc_pkg::SERIAL_LO)) && (rs <= SUM_W'(gdc_pkg::SERIAL_HI));
  assign diff_raw = sa_r - sb_r;

  assign dd   = gdc_pkg::SER_W'(n_r) - d_r;
  assign ylen = 9'd365 + 9'(leap_r);
  assign mlen = gdc_pkg::month_len(mo_r, leap_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    out_valid_nxt  = 1'b0;
    sel_b_nxt      = sel_b_r;
    day_a_nxt      = day_a_r;
    day_b_nxt      = day_b_r;
    month_a_nxt    = month_a_r;
    month_b_nxt    = month_b_r;
    year_b_nxt     = year_b_r;
    cnt_nxt        = cnt_r;
    sy_nxt         = sy_r;
    q100p_nxt      = q100p_r;
    leap_nxt       = leap_r;
    d_nxt          = d_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    n_nxt          = n_r;
    doy_nxt        = doy_r;
    mo_nxt         = mo_r;
    out_day_nxt    = out_day_r;
    out_month_nxt  = out_month_r;
    out_year_nxt   = out_year_r;
    out_diff_nxt   = out_diff_r;
    out_before_nxt = out_before_r;
    out_equal_nxt  = out_equal_r;
    out_rerr_nxt   = out_rerr_r;

    unique case (state_r)
      gdc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt     = gdc_pkg::cmd_t'(in_cmd);
          day_a_nxt   = in_day_a;
          month_a_nxt = in_month_a;
          day_b_nxt   = in_day_b;
          month_b_nxt = in_month_b;
          year_b_nxt  = in_year_b;
          cnt_nxt     = in_day_count;
          sy_nxt      = gdc_pkg::SY_W'(in_year_a) + gdc_pkg::YEAR_SHIFT;
          sel_b_nxt   = 1'b0;
          state_nxt   = gdc_pkg::ST_YDIV;
        end
      end
      gdc_pkg::ST_YDIV: begin
        state_nxt = gdc_pkg::ST_YMUL;
      end
      gdc_pkg::ST_YMUL: begin
        // sy / 100 -> (sy - 1) / 100 drops by one on a century boundary
        q100p_nxt = (r100 == '0) ? (q_est - 8'd1) : q_est;
        leap_nxt  = (sy_r[1:0] == 2'd0) && ((r100 != '0) || (q_est[1:0] == 2'd0));
        state_nxt = gdc_pkg::ST_YSUM;
      end
      gdc_pkg::ST_YSUM: begin
        d_nxt     = d_sum;
        state_nxt = conv_phase_r ? gdc_pkg::ST_YCHK : gdc_pkg::ST_SER;
      end
      gdc_pkg::ST_SER: begin
        if (!sel_b_r) begin
          sa_nxt    = s_val;
          sel_b_nxt = 1'b1;
          sy_nxt    = gdc_pkg::SY_W'(year_b_r) + gdc_pkg::YEAR_SHIFT;
          state_nxt = gdc_pkg::ST_YDIV;
        end else begin
          sb_nxt    = s_val;
          state_nxt = gdc_pkg::ST_DECIDE;
        end
      end
      gdc_pkg::ST_DECIDE: begin
        out_before_nxt = sa_r < sb_r;
        out_equal_nxt  = sa_r == sb_r;
        out_day_nxt    = '0;
        out_month_nxt  = '0;
        out_year_nxt   = '0;
        out_diff_nxt   = '0;
        out_rerr_nxt   = 1'b0;
        case (cmd_r)
          gdc_pkg::CMD_ADD, gdc_pkg::CMD_SUB: begin
            if (rs_ok) begin
              n_nxt     = gdc_pkg::N_W'(rs - SUM_W'(1));
              state_nxt = gdc_pkg::ST_EST;
            end else begin
              out_rerr_nxt  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = gdc_pkg::ST_IDLE;
            end
          end
          gdc_pkg::CMD_DIFF: begin
            if (sa_r < sb_r) begin
              out_diff_nxt = '1;
            end else begin
              out_diff_nxt = (diff_raw > gdc_pkg::DIFF_MAX) ? gdc_pkg::DIFF_MAX : diff_raw;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = gdc_pkg::ST_IDLE;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = gdc_pkg::ST_IDLE;
          end
        endcase
      end
      gdc_pkg::ST_EST: begin
        state_nxt = gdc_pkg::ST_ESTL;
      end
      gdc_pkg::ST_ESTL: begin
        sy_nxt    = gdc_pkg::SY_W'(prod_r[gdc_pkg::PROD_W-1:gdc_pkg::YEAR_LSB]) +
                    gdc_pkg::SY_W'(1);
        state_nxt = gdc_pkg::ST_YDIV;
      end
      gdc_pkg::ST_YCHK: begin
        // walk the year estimate until D(sy) <= n < D(sy) + year length
        if (gdc_pkg::SER_W'(n_r) < d_r) begin
          sy_nxt    = sy_m1;
          state_nxt = gdc_pkg::ST_YDIV;
        end else if (dd >= gdc_pkg::SER_W'(ylen)) begin
          sy_nxt    = sy_r + gdc_pkg::SY_W'(1);
          state_nxt = gdc_pkg::ST_YDIV;
        end else begin
          doy_nxt      = dd[8:0];
          mo_nxt       = 4'd0;
          out_year_nxt = 14'(sy_r - gdc_pkg::YEAR_SHIFT);
          state_nxt    = gdc_pkg::ST_MON;
        end
      end
      gdc_pkg::ST_MON: begin
        if ((mo_r == 4'd11) || (doy_r < 9'(mlen))) begin
          out_day_nxt   = 5'(doy_r + 9'd1);
          out_month_nxt = mo_r + 4'd1;
          out_valid_nxt = 1'b1;
          state_nxt     = gdc_pkg::ST_IDLE;
        end else begin
          doy_nxt = doy_r - 9'(mlen);
          mo_nxt  = mo_r + 4'd1;
        end
      end
      default: begin
        state_nxt = gdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    conv_phase_nxt = conv_phase_r;
    if (state_r == gdc_pkg::ST_IDLE) begin
      conv_phase_nxt = 1'b0;
    end else if (state_r == gdc_pkg::ST_EST) begin
      conv_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gdc_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      conv_phase_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      conv_phase_r <= conv_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    sel_b_r      <= sel_b_nxt;
    day_a_r      <= day_a_nxt;
    day_b_r      <= day_b_nxt;
    month_a_r    <= month_a_nxt;
    month_b_r    <= month_b_nxt;
    year_b_r     <= year_b_nxt;
    cnt_r        <= cnt_nxt;
    sy_r         <= sy_nxt;
    prod_r       <= prod_nxt;
    q100p_r      <= q100p_nxt;
    leap_r       <= leap_nxt;
    d_r          <= d_nxt;
    sa_r         <= sa_nxt;
    sb_r         <= sb_nxt;
    n_r          <= n_nxt;
    doy_r        <= doy_nxt;
    mo_r         <= mo_nxt;
    out_day_r    <= out_day_nxt;
    out_month_r  <= out_month_nxt;
    out_year_r   <= out_year_nxt;
    out_diff_r   <= out_diff_nxt;
    out_before_r <= out_before_nxt;
    out_equal_r  <= out_equal_nxt;
    out_rerr_r   <= out_rerr_nxt;
  end

  assign busy            = (state_r != gdc_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_day         = out_day_r;
  assign out_month       = out_month_r;
  assign out_year        = out_year_r;
  assign out_diff_days   = out_diff_r;
  assign out_a_before_b  = out_before_r;
  assign out_a_equals_b  = out_equal_r;
  assign out_range_error = out_rerr_r;

`ifndef SYNTHESIS
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == gdc_pkg::ST_IDLE))
    else $error("result strobe while sequencer busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_rerr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_day == '0 && out_month == '0 && out_year == '0))
    else $error("range error with nonzero date");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_a_before_b && out_a_equals_b))
    else $error("before and equal both set");

  a_diff_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r == gdc_pkg::CMD_DIFF) |->
      (out_a_before_b == (out_diff_days == -23'sd1)))
    else $error("difference sign disagrees with compare flag");
`endif

endmodule
